// ===== rtl/scp_pkg.sv =====
// Shared widths, fixed-point constants and types of the sine and cosine pipeline.
package scp_pkg;

    // Formats of the ports.
    localparam int ANGLE_FRAC_BITS = 12;
    localparam int OUT_FRAC_BITS   = 14;
    localparam int ANGLE_W         = ANGLE_FRAC_BITS + 4;
    localparam int OUT_W           = OUT_FRAC_BITS + 2;
    localparam int TDATA_IN_W      = ((ANGLE_W + 7) / 8) * 8;
    localparam int TDATA_OUT_W     = ((2 * OUT_W + 7) / 8) * 8;

    // Internal Q.30 format.
    localparam int WQ      = 30;
    localparam int ANG_SH  = WQ - ANGLE_FRAC_BITS;
    localparam int RND_SH  = WQ - OUT_FRAC_BITS;
    localparam int VW      = ANGLE_W + ANG_SH;   // scaled angle magnitude bits
    localparam int MW      = 33;                 // reduced angle, below 2pi
    localparam int XW      = 32;                 // half-turn folded angle, up to pi
    localparam int AW      = 31;                 // quarter-turn folded angle, up to pi/2
    localparam int SQ_W    = 32;
    localparam int KS_W    = 25;
    localparam int KC_W    = 28;
    localparam int US_W    = 30;
    localparam int UC_W    = 32;
    localparam int S_W     = 32;
    localparam int C_W     = 33;

    localparam logic [MW-1:0] TWO_PI_Q  = 33'd6746518852;
    localparam logic [XW-1:0] PI_Q      = 32'd3373259426;
    localparam logic [AW-1:0] HALF_PI_Q = 31'd1686629713;
    localparam logic [AW-1:0] ONE_Q     = 31'd1073741824;

    // Polynomial coefficients in Q.30.
    localparam logic [22:0] SIN_C4 = 23'd8171175;
    localparam logic [27:0] SIN_C2 = 28'd178294830;
    localparam logic [25:0] COS_C4 = 26'd39782135;
    localparam logic [29:0] COS_C2 = 30'd533327564;

    typedef struct packed {
        logic sin_neg;
        logic cos_neg;
    } t_sign;

endpackage

// ===== rtl/scp_reduce.sv =====
// Angle reduction into [0, 2pi) and folding into [0, pi/2], three register stages.
module scp_reduce (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  logic signed [scp_pkg::ANGLE_W-1:0]   i_angle,
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output logic        [scp_pkg::AW-1:0]        o_a,
    output scp_pkg::t_sign                       o_sign
);

    localparam int VW = scp_pkg::VW;
    localparam int MW = scp_pkg::MW;
    localparam int XW = scp_pkg::XW;
    localparam int AW = scp_pkg::AW;

    localparam logic signed [VW:0] TWO_PI_S     = signed'((VW + 1)'(scp_pkg::TWO_PI_Q));
    localparam logic signed [VW:0] FOUR_PI_S    = TWO_PI_S + TWO_PI_S;
    localparam logic signed [VW:0] NEG_TWO_PI_S = -TWO_PI_S;

    logic                r_v1, r_v2, r_v3;
    logic                rdy1, rdy2, rdy3;
    logic [MW-1:0]       r_m, n_m;
    logic [XW-1:0]       r_x, n_x;
    scp_pkg::t_sign      r_sign2, n_sign2, r_sign3;
    logic [AW-1:0]       r_a, n_a;

    logic signed [VW:0]  v, v_p2, v_p4, v_m2;
    logic [XW-1:0]       d;

    assign rdy3    = ~r_v3 | i_ready;
    assign rdy2    = ~r_v2 | rdy3;
    assign rdy1    = ~r_v1 | rdy2;
    assign o_ready = rdy1;

    // Stage 1: scale to Q.30 and take the true modulo 2pi. The scaled input
    // spans less than two turns on either side, so one of four offsets fits.
    always_comb begin
        v    = signed'({i_angle[scp_pkg::ANGLE_W-1], i_angle, {scp_pkg::ANG_SH{1'b0}}});
        v_p2 = v + TWO_PI_S;
        v_p4 = v + FOUR_PI_S;
        v_m2 = v - TWO_PI_S;
        if (v < 0) begin
            n_m = (v < NEG_TWO_PI_S) ? v_p4[MW-1:0] : v_p2[MW-1:0];
        end else if (v >= TWO_PI_S) begin
            n_m = v_m2[MW-1:0];
        end else begin
            n_m = v[MW-1:0];
        end
    end

    // Stage 2: half-turn fold and the sign of each function.
    always_comb begin
        if (r_m <= MW'(scp_pkg::PI_Q)) begin
            n_x             = r_m[XW-1:0];
            n_sign2.sin_neg = 1'b0;
            n_sign2.cos_neg = (r_m[XW-1:0] > XW'(scp_pkg::HALF_PI_Q));
        end else begin
            n_x             = XW'(r_m - MW'(scp_pkg::PI_Q));
            n_sign2.sin_neg = 1'b1;
            n_sign2.cos_neg = (n_x < XW'(scp_pkg::HALF_PI_Q));
        end
    end

    // Stage 3: mirror about pi/2.
    always_comb begin
        d   = scp_pkg::PI_Q - r_x;
        n_a = (d < r_x) ? d[AW-1:0] : r_x[AW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (rdy1) begin
                r_v1 <= i_valid;
            end
            if (rdy2) begin
                r_v2 <= r_v1;
            end
            if (rdy3) begin
                r_v3 <= r_v2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy1 && i_valid) begin
            r_m <= n_m;
        end
        if (rdy2 && r_v1) begin
            r_x     <= n_x;
            r_sign2 <= n_sign2;
        end
        if (rdy3 && r_v2) begin
            r_a     <= n_a;
            r_sign3 <= r_sign2;
        end
    end

    assign o_valid = r_v3;
    assign o_a     = r_a;
    assign o_sign  = r_sign3;

endmodule

// ===== rtl/scp_poly.sv =====
// Horner evaluation of the sine and cosine polynomials, four register stages.
module scp_poly (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic        [scp_pkg::AW-1:0]     i_a,
    input  scp_pkg::t_sign                    i_sign,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic        [scp_pkg::S_W-1:0]    o_s,
    output logic signed [scp_pkg::C_W-1:0]    o_c,
    output scp_pkg::t_sign                    o_sign
);

    localparam int AW   = scp_pkg::AW;
    localparam int SQ_W = scp_pkg::SQ_W;
    localparam int KS_W = scp_pkg::KS_W;
    localparam int KC_W = scp_pkg::KC_W;
    localparam int US_W = scp_pkg::US_W;
    localparam int UC_W = scp_pkg::UC_W;
    localparam int S_W  = scp_pkg::S_W;
    localparam int C_W  = scp_pkg::C_W;
    localparam int WQ   = scp_pkg::WQ;

    logic                  r_v4, r_v5, r_v6, r_v7;
    logic                  rdy4, rdy5, rdy6, rdy7;

    logic [AW-1:0]         r_a4, r_a5, r_a6;
    scp_pkg::t_sign        r_sg4, r_sg5, r_sg6, r_sg7;
    logic [SQ_W-1:0]       r_sq4, r_sq5;
    logic [KS_W-1:0]       r_ks;
    logic [KC_W-1:0]       r_kc;
    logic [US_W-1:0]       r_us;
    logic [UC_W-1:0]       r_uc;
    logic [S_W-1:0]        r_s;
    logic signed [C_W-1:0] r_c;

    logic [2*AW-1:0]       prod_sq;
    logic [22+SQ_W:0]      prod_ks;
    logic [25+SQ_W:0]      prod_kc;
    logic [27:0]           t_s;
    logic [29:0]           t_c;
    logic [27+SQ_W:0]      prod_us;
    logic [29+SQ_W:0]      prod_uc;
    logic [AW-1:0]         p;
    logic [2*AW-1:0]       prod_s;
    logic signed [C_W-1:0] n_c;

    assign rdy7    = ~r_v7 | i_ready;
    assign rdy6    = ~r_v6 | rdy7;
    assign rdy5    = ~r_v5 | rdy6;
    assign rdy4    = ~r_v4 | rdy5;
    assign o_ready = rdy4;

    always_comb begin
        // Stage 4: square of the folded angle.
        prod_sq = i_a * i_a;
        // Stage 5: innermost products of both polynomials.
        prod_ks = scp_pkg::SIN_C4 * r_sq4;
        prod_kc = scp_pkg::COS_C4 * r_sq4;
        // Stage 6: inner differences, then times the square.
        t_s     = scp_pkg::SIN_C2 - 28'(r_ks);
        t_c     = scp_pkg::COS_C2 - 30'(r_kc);
        prod_us = t_s * r_sq5;
        prod_uc = t_c * r_sq5;
        // Stage 7: outer terms. The cosine may dip just below zero near pi/2.
        p       = scp_pkg::ONE_Q - AW'(r_us);
        prod_s  = p * r_a6;
        n_c     = signed'(C_W'(scp_pkg::ONE_Q)) - signed'(C_W'(r_uc));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            r_v6 <= 1'b0;
            r_v7 <= 1'b0;
        end else begin
            if (rdy4) begin
                r_v4 <= i_valid;
            end
            if (rdy5) begin
                r_v5 <= r_v4;
            end
            if (rdy6) begin
                r_v6 <= r_v5;
            end
            if (rdy7) begin
                r_v7 <= r_v6;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy4 && i_valid) begin
            r_sq4 <= prod_sq[WQ+SQ_W-1:WQ];
            r_a4  <= i_a;
            r_sg4 <= i_sign;
        end
        if (rdy5 && r_v4) begin
            r_ks  <= prod_ks[WQ+KS_W-1:WQ];
            r_kc  <= prod_kc[WQ+KC_W-1:WQ];
            r_sq5 <= r_sq4;
            r_a5  <= r_a4;
            r_sg5 <= r_sg4;
        end
        if (rdy6 && r_v5) begin
            r_us  <= prod_us[WQ+US_W-1:WQ];
            r_uc  <= prod_uc[WQ+UC_W-1:WQ];
            r_a6  <= r_a5;
            r_sg6 <= r_sg5;
        end
        if (rdy7 && r_v6) begin
            r_s   <= prod_s[WQ+S_W-1:WQ];
            r_c   <= n_c;
            r_sg7 <= r_sg6;
        end
    end

    assign o_valid = r_v7;
    assign o_s     = r_s;
    assign o_c     = r_c;
    assign o_sign  = r_sg7;

endmodule

// ===== rtl/scp_round.sv =====
// Sign, rounding and saturation to the output format, held in the output register.
module scp_round (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic        [scp_pkg::S_W-1:0]    i_s,
    input  logic signed [scp_pkg::C_W-1:0]    i_c,
    input  scp_pkg::t_sign                    i_sign,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic        [scp_pkg::OUT_W-1:0]  o_sine,
    output logic        [scp_pkg::OUT_W-1:0]  o_cosine
);

    localparam int MAGW   = scp_pkg::C_W;
    localparam int OUT_W  = scp_pkg::OUT_W;
    localparam int RND_SH = scp_pkg::RND_SH;

    localparam logic [MAGW:0] ONE_BIT  = (MAGW + 1)'(1);
    localparam logic [MAGW:0] LIM      = ONE_BIT << scp_pkg::OUT_FRAC_BITS;
    localparam logic [MAGW:0] RND_HALF = (RND_SH > 0) ? (ONE_BIT << (RND_SH - 1)) : '0;

    logic                   r_v8;
    logic                   rdy8;
    logic [OUT_W-1:0]       r_sine, r_cosine;
    logic signed [MAGW:0]   c_ext, c_val;
    logic                   c_neg;
    logic [MAGW:0]          c_abs;

    // Round half away from zero on the magnitude, limit to one, then sign.
    function automatic logic [OUT_W-1:0] to_out(input logic neg, input logic [MAGW-1:0] mag);
        logic [MAGW:0] q;
        q = ({1'b0, mag} + RND_HALF) >> RND_SH;
        if (q > LIM) begin
            q = LIM;
        end
        if (neg) begin
            q = ~q + ONE_BIT;
        end
        return q[OUT_W-1:0];
    endfunction

    always_comb begin
        c_ext = signed'({i_c[MAGW-1], i_c});
        c_val = i_sign.cos_neg ? -c_ext : c_ext;
        c_neg = c_val[MAGW];
        c_abs = c_neg ? unsigned'(-c_val) : unsigned'(c_val);
    end

    assign rdy8    = ~r_v8 | i_ready;
    assign o_ready = rdy8;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v8 <= 1'b0;
        end else if (rdy8) begin
            r_v8 <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy8 && i_valid) begin
            r_sine   <= to_out(i_sign.sin_neg, MAGW'(i_s));
            r_cosine <= to_out(c_neg, c_abs[MAGW-1:0]);
        end
    end

    assign o_valid  = r_v8;
    assign o_sine   = r_sine;
    assign o_cosine = r_cosine;

endmodule

// ===== rtl/sine_cosine_polynomial.sv =====
// Top level: a stream of Q3.12 angles in, a stream of Q1.14 sine and cosine pairs out.
// The block accepts one angle every clock unless back-pressure has filled it, and
// returns its sine and cosine in order. Eight register stages carry the work: three
// reduce the angle modulo 2pi and fold it into the first quarter turn, four evaluate
// both polynomials, two of them with a multiplier per lane, and the last rounds,
// saturates to plus or minus one and holds the result. Each stage moves whenever
// the stage after it is empty or moving, so back-pressure on the output fills
// empty stages first and input is refused only once all eight are occupied.
module sine_cosine_polynomial (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    // angle[15:0]
    input  logic [scp_pkg::TDATA_IN_W-1:0]      i_s_axis_tdata,
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    // sine[15:0], cosine[31:16]
    output logic [scp_pkg::TDATA_OUT_W-1:0]     o_m_axis_tdata
);

    logic                                  red_valid, poly_ready;
    logic        [scp_pkg::AW-1:0]         red_a;
    scp_pkg::t_sign                        red_sign;
    logic                                  poly_valid, rnd_ready;
    logic        [scp_pkg::S_W-1:0]        poly_s;
    logic signed [scp_pkg::C_W-1:0]        poly_c;
    scp_pkg::t_sign                        poly_sign;
    logic        [scp_pkg::OUT_W-1:0]      sine, cosine;

    scp_reduce u_reduce (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .o_ready (o_s_axis_tready),
        .i_angle (signed'(i_s_axis_tdata[scp_pkg::ANGLE_W-1:0])),
        .o_valid (red_valid),
        .i_ready (poly_ready),
        .o_a     (red_a),
        .o_sign  (red_sign)
    );

    scp_poly u_poly (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (red_valid),
        .o_ready (poly_ready),
        .i_a     (red_a),
        .i_sign  (red_sign),
        .o_valid (poly_valid),
        .i_ready (rnd_ready),
        .o_s     (poly_s),
        .o_c     (poly_c),
        .o_sign  (poly_sign)
    );

    scp_round u_round (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (poly_valid),
        .o_ready  (rnd_ready),
        .i_s      (poly_s),
        .i_c      (poly_c),
        .i_sign   (poly_sign),
        .o_valid  (o_m_axis_tvalid),
        .i_ready  (i_m_axis_tready),
        .o_sine   (sine),
        .o_cosine (cosine)
    );

    assign o_m_axis_tdata = scp_pkg::TDATA_OUT_W'({cosine, sine});

endmodule

// ===== sim/tb.sv =====
// Self-checking stream testbench for the polynomial sine and cosine block.
`timescale 1ns / 100ps

module tb;

    localparam int ANGLE_W = scp_pkg::ANGLE_W;
    localparam int OUT_W   = scp_pkg::OUT_W;

    // Q.30 working format of the predictor.
    localparam int              SCALE_SH     = 30 - scp_pkg::ANGLE_FRAC_BITS;
    localparam int              ROUND_SH     = 30 - scp_pkg::OUT_FRAC_BITS;
    localparam longint          ANGLE_SCALE  = 64'sd1 <<< SCALE_SH;
    localparam longint          ONE_Q30      = 64'sd1073741824;
    localparam longint          PI_Q30       = 64'sd3373259426;
    localparam longint          HALF_PI_Q30  = 64'sd1686629713;
    localparam longint          TWO_PI_Q30   = 64'sd6746518852;
    localparam longint unsigned SIN_A4       = 64'd8171175;
    localparam longint unsigned SIN_A2       = 64'd178294830;
    localparam longint unsigned COS_A4       = 64'd39782135;
    localparam longint unsigned COS_A2       = 64'd533327564;
    localparam longint unsigned UNIT_Q14     = 64'd1 << scp_pkg::OUT_FRAC_BITS;

    localparam int RANDOM_ANGLES = 700;
    localparam int NUM_DIRECTED  = 20;

    // Laid out like the output tdata: sine in the low half, cosine above it.
    typedef struct packed {
        logic [OUT_W-1:0] cosine;
        logic [OUT_W-1:0] sine;
    } sc_pair_t;

    typedef struct packed {
        logic [ANGLE_W-1:0] angle;
        logic               known;
        logic [OUT_W-1:0]   sine;
        logic [OUT_W-1:0]   cosine;
    } dir_row_t;

    // Only the zero angle has a result that can be written down directly.
    localparam dir_row_t DIRECTED_ROWS [NUM_DIRECTED] = '{
        '{16'sd0,      1'b1, 16'sd0, 16'sd16384},
        '{16'sd1,      1'b0, 16'sd0, 16'sd0},
        '{-16'sd1,     1'b0, 16'sd0, 16'sd0},
        '{16'sd32767,  1'b0, 16'sd0, 16'sd0},
        '{-16'sd32768, 1'b0, 16'sd0, 16'sd0},
        '{16'h5555,    1'b0, 16'sd0, 16'sd0},
        '{16'hAAAA,    1'b0, 16'sd0, 16'sd0},
        '{16'sd6433,   1'b0, 16'sd0, 16'sd0},
        '{16'sd6434,   1'b0, 16'sd0, 16'sd0},
        '{16'sd12867,  1'b0, 16'sd0, 16'sd0},
        '{16'sd12868,  1'b0, 16'sd0, 16'sd0},
        '{16'sd19301,  1'b0, 16'sd0, 16'sd0},
        '{16'sd19302,  1'b0, 16'sd0, 16'sd0},
        '{16'sd25735,  1'b0, 16'sd0, 16'sd0},
        '{16'sd25736,  1'b0, 16'sd0, 16'sd0},
        '{-16'sd25735, 1'b0, 16'sd0, 16'sd0},
        '{-16'sd25736, 1'b0, 16'sd0, 16'sd0},
        '{-16'sd25737, 1'b0, 16'sd0, 16'sd0},
        '{-16'sd12868, 1'b0, 16'sd0, 16'sd0},
        '{-16'sd6434,  1'b0, 16'sd0, 16'sd0}
    };

    logic                               i_clk = 1'b0;
    logic                               i_rst_n = 1'b0;
    logic                               i_s_axis_tvalid = 1'b0;
    logic                               o_s_axis_tready;
    // angle[15:0]
    logic [scp_pkg::TDATA_IN_W-1:0]     i_s_axis_tdata = '0;
    logic                               o_m_axis_tvalid;
    logic                               i_m_axis_tready = 1'b0;
    // sine[15:0], cosine[31:16]
    logic [scp_pkg::TDATA_OUT_W-1:0]    o_m_axis_tdata;

    sc_pair_t pending_pairs[$];
    int       n_angles = 0;
    int       n_checked = 0;
    int       n_errors = 0;
    bit       calm = 1'b0;

    sine_cosine_polynomial u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    function automatic longint unsigned q30_mul(input longint unsigned x,
                                                input longint unsigned y);
        return (x * y) >> 30;
    endfunction

    // Rounds a Q.30 value half away from zero to Q1.14 and clamps to one.
    function automatic logic [OUT_W-1:0] round_sat(input longint v);
        bit                neg;
        longint unsigned   mag;
        neg = v < 0;
        mag = neg ? longint'(-v) : v;
        mag = (mag + (64'd1 << (ROUND_SH - 1))) >> ROUND_SH;
        if (mag > UNIT_Q14) begin
            mag = UNIT_Q14;
        end
        return neg ? OUT_W'(-mag) : OUT_W'(mag);
    endfunction

    function automatic sc_pair_t sincos_of(input logic signed [ANGLE_W-1:0] angle);
        longint          red;
        longint          half;
        longint          quad;
        longint          cos_val;
        longint unsigned ua;
        longint unsigned sq;
        longint unsigned t;
        longint unsigned p;
        longint unsigned sin_mag;
        bit              sin_neg;
        bit              cos_neg;
        sc_pair_t        r;
        red = (longint'(angle) * ANGLE_SCALE) % TWO_PI_Q30;
        if (red < 0) begin
            red += TWO_PI_Q30;
        end
        if (red <= PI_Q30) begin
            half    = red;
            sin_neg = 1'b0;
            cos_neg = half > HALF_PI_Q30;
        end else begin
            half    = red - PI_Q30;
            sin_neg = 1'b1;
            cos_neg = half < HALF_PI_Q30;
        end
        quad = (PI_Q30 - half < half) ? PI_Q30 - half : half;
        ua   = quad;

        sq      = q30_mul(ua, ua);
        t       = SIN_A2 - q30_mul(SIN_A4, sq);
        p       = longint'(ONE_Q30) - q30_mul(t, sq);
        sin_mag = q30_mul(p, ua);

        t       = COS_A2 - q30_mul(COS_A4, sq);
        cos_val = ONE_Q30 - longint'(q30_mul(t, sq));

        r.sine   = round_sat(sin_neg ? -longint'(sin_mag) : longint'(sin_mag));
        r.cosine = round_sat(cos_neg ? -cos_val : cos_val);
        return r;
    endfunction

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Sends one angle after a random gap and records its expected pair on transfer.
    task automatic send_angle(input logic [ANGLE_W-1:0] angle, input sc_pair_t expected);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 17);
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= angle;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        pending_pairs.push_back(expected);
        n_angles++;
    endtask

    initial begin : stimulus
        logic [ANGLE_W-1:0] angle;
        longint             base;
        int                 kind;
        int                 k;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (DIRECTED_ROWS[i]) begin
            send_angle(DIRECTED_ROWS[i].angle,
                       DIRECTED_ROWS[i].known ?
                           sc_pair_t'{DIRECTED_ROWS[i].cosine, DIRECTED_ROWS[i].sine} :
                           sincos_of(DIRECTED_ROWS[i].angle));
        end

        // Let the pipeline drain completely before the random part.
        i_s_axis_tvalid <= 1'b0;
        while (pending_pairs.size() != 0) @(posedge i_clk);

        for (int i = 0; i < RANDOM_ANGLES; i++) begin
            calm = (i >= 250 && i < 350);
            kind = $urandom_range(0, 9);
            if (kind <= 5) begin
                angle = ANGLE_W'($urandom);
            end else if (kind <= 8) begin
                // Close to a multiple of a quarter turn, where the folds switch.
                k     = int'($urandom_range(0, 10)) - 5;
                base  = (longint'(k) * HALF_PI_Q30) / ANGLE_SCALE;
                angle = ANGLE_W'(base + longint'($urandom_range(0, 8)) - 4);
            end else if ($urandom_range(0, 1) == 0) begin
                angle = ANGLE_W'(16'sh7FFF - $urandom_range(0, 15));
            end else begin
                angle = ANGLE_W'(16'sh8000 + $urandom_range(0, 15));
            end
            send_angle(angle, sincos_of(angle));
        end
        calm = 1'b0;
        i_s_axis_tvalid <= 1'b0;

        while (pending_pairs.size() != 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);

        $display("Sent %0d angles (%0d directed, including both extremes and fold edges),",
                 n_angles, NUM_DIRECTED);
        $display("checked %0d sine/cosine pairs under random source gaps and sink stalls.",
                 n_checked);
        if (n_errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // Sink side: a random stall before each transfer, none during the calm stretch.
    initial begin : sink
        int stall;
        @(posedge i_clk);
        forever begin
            stall = calm ? 0 : $urandom_range(0, 17);
            if (stall > 0) begin
                i_m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_m_axis_tready <= 1'b1;
            @(posedge i_clk);
            while (!o_m_axis_tvalid) @(posedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        sc_pair_t want;
        sc_pair_t got;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got = o_m_axis_tdata[2*OUT_W-1:0];
            if (pending_pairs.size() == 0) begin
                $error("unexpected result: sine %0d, cosine %0d",
                       $signed(got.sine), $signed(got.cosine));
                n_errors++;
            end else begin
                want = pending_pairs.pop_front();
                n_checked++;
                if (got.sine !== want.sine) begin
                    $error("sine mismatch: expected %0d, got %0d",
                           $signed(want.sine), $signed(got.sine));
                    n_errors++;
                end
                if (got.cosine !== want.cosine) begin
                    $error("cosine mismatch: expected %0d, got %0d",
                           $signed(want.cosine), $signed(got.cosine));
                    n_errors++;
                end
            end
        end
    end

    initial begin
        #5_000_000;
        $display("Timeout with %0d results outstanding.", pending_pairs.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/scp_pkg.sv
rtl/scp_reduce.sv
rtl/scp_poly.sv
rtl/scp_round.sv
rtl/sine_cosine_polynomial.sv
sim/tb.sv
